// ===== rtl/core/bubble_sort_engine_macros.svh =====
// ----------------------------------------------------------------------------
// bubble_sort_engine_macros.svh
// assertion macros shared by the sort engine
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_ENGINE_MACROS_SVH
`define BUBBLE_SORT_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bse assertion failed");

// next-cycle implication, checked outside reset
`define BSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bse assertion failed");

`endif

// ===== rtl/core/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// shared types of the sort engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bse_pkg;

    // load: taking elements, settle: chain drains, emit: sorted values go out
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/bubble_sort_engine.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_engine
// sorts a set of signed values into ascending order in a compare-swap chain
// ----------------------------------------------------------------------------
// input channel (i_valid / o_ready, i_value, i_last): one element per transfer;
//   i_last marks the final element of a set. elements beyond MAX_ELEMENTS are
//   dropped, but their last flag still closes the set.
// each element enters the head cell and ripples down a row of MAX_ELEMENTS
//   cells, one hop per cycle; a cell keeps the smaller value and hands the
//   larger one to its right neighbor, so the row stays in ascending order.
// after the last transfer the chain settles, then the row shifts toward the
//   head, one sorted value per output transfer (o_valid / i_ready, o_value_res,
//   o_last_res); o_last_res flags the final one.
// a set of n elements passes through n input transfers, the settle phase of
//   the cell row and n output transfers; the first result shows once the
//   settle phase after the last input transfer ends.
// the block takes no input from the last input transfer until the final
//   result has been transferred.
// a stalled receiver freezes the row; o_value_res is the head cell itself.
// reset (i_rst_n low, synchronous) empties every cell and returns to loading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bubble_sort_engine_macros.svh"

module bubble_sort_engine #(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_value_res,
    output logic                         o_last_res
);

    import bse_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;     // elements stored in this set
    logic [CW-1:0]  r_settle, n_settle;   // cycles left for the chain to drain

    logic           w_in_xfer;
    logic           w_out_xfer;
    logic           w_shift;
    logic           w_store;

    // cell row interconnect, index MAX_ELEMENTS is the empty end of the row
    logic                  w_full     [MAX_ELEMENTS+1];
    logic [DATA_WIDTH-1:0] w_val      [MAX_ELEMENTS+1];
    logic                  w_pass_vld [MAX_ELEMENTS+1];
    logic [DATA_WIDTH-1:0] w_pass_val [MAX_ELEMENTS+1];

    assign o_ready    = (r_state == ST_LOAD);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_store    = w_in_xfer && (r_count < CW'(MAX_ELEMENTS));
    assign o_valid    = (r_state == ST_EMIT) && w_full[0];
    assign w_out_xfer = o_valid && i_ready;
    assign w_shift    = w_out_xfer;

    // head of the row is fed by the input transfer
    assign w_pass_vld[0] = w_store;
    assign w_pass_val[0] = i_value;

    // nothing lives past the tail
    assign w_full[MAX_ELEMENTS] = 1'b0;
    assign w_val[MAX_ELEMENTS]  = '0;

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        bse_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_shift),
            .i_pass_vld (w_pass_vld[g]),
            .i_pass_val (w_pass_val[g]),
            .i_nbr_full (w_full[g+1]),
            .i_nbr_val  (w_val[g+1]),
            .o_full     (w_full[g]),
            .o_val      (w_val[g]),
            .o_pass_vld (w_pass_vld[g+1]),
            .o_pass_val (w_pass_val[g+1])
        );
    end

    assign o_value_res = w_val[0];
    assign o_last_res  = !w_full[1];

    // control sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_settle = r_settle;
        unique case (r_state)
            ST_LOAD: begin
                if (w_store) begin
                    n_count = r_count + 1'b1;
                end
                if (w_in_xfer && i_last) begin
                    n_state  = ST_SETTLE;
                    n_count  = '0;
                    n_settle = CW'(MAX_ELEMENTS);
                end
            end
            ST_SETTLE: begin
                if (r_settle == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_settle = r_settle - 1'b1;
                end
            end
            ST_EMIT: begin
                // final value leaves, row is empty again
                if (w_out_xfer && o_last_res) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_settle <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_settle <= n_settle;
        end
    end

    // checks
    `BSE_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `BSE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ELEMENTS))
    `BSE_ASSERT_IMP(a_emit_nonempty, i_clk, i_rst_n, r_state == ST_EMIT, w_full[0])
    `BSE_ASSERT_NXT(a_back_to_load, i_clk, i_rst_n, w_out_xfer && o_last_res, o_ready && !w_full[0])

endmodule

// ===== rtl/core/bse_cell.sv =====
// ----------------------------------------------------------------------------
// bse_cell
// one compare-swap cell: keeps the smaller value, passes the larger one on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic                  i_pass_vld,
    input  logic [DATA_WIDTH-1:0] i_pass_val,
    input  logic                  i_nbr_full,
    input  logic [DATA_WIDTH-1:0] i_nbr_val,
    output logic                  o_full,
    output logic [DATA_WIDTH-1:0] o_val,
    output logic                  o_pass_vld,
    output logic [DATA_WIDTH-1:0] o_pass_val
);

    import bse_pkg::*;

    logic                  r_full, n_full;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic                  r_pass_vld, n_pass_vld;
    logic [DATA_WIDTH-1:0] r_pass_val, n_pass_val;

    always_comb begin
        n_full     = r_full;
        n_val      = r_val;
        n_pass_vld = 1'b0;
        n_pass_val = r_pass_val;
        if (i_shift) begin
            // drain toward the head of the chain
            n_full = i_nbr_full;
            n_val  = i_nbr_val;
        end else if (i_pass_vld) begin
            if (!r_full) begin
                n_full = 1'b1;
                n_val  = i_pass_val;
            end else if ($signed(i_pass_val) < $signed(r_val)) begin
                n_val      = i_pass_val;
                n_pass_vld = 1'b1;
                n_pass_val = r_val;
            end else begin
                n_pass_vld = 1'b1;
                n_pass_val = i_pass_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            r_full     <= n_full;
            r_pass_vld <= n_pass_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_pass_val <= n_pass_val;
    end

    assign o_full     = r_full;
    assign o_val      = r_val;
    assign o_pass_vld = r_pass_vld;
    assign o_pass_val = r_pass_val;

endmodule

// ===== test/bubble_sort_engine_tb.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_engine_tb
// self-checking bench for the signed bubble sort engine
// ----------------------------------------------------------------------------
// sets of signed values go in one transfer at a time, the final one flagged.
// a software copy of the engine gathers each accepted set, orders it and
// queues the ascending values it must see back, each checked field by field.
// the directed sets cover the value extremes, duplicates, sorted and reversed
// order and single-element sets. the random sets are mostly short, with one
// set that overruns the storage: its tail is dropped, its last flag still
// closes the set. both handshakes idle at random, the receiver once holds
// off long enough to back up the input; the sender twice awaits a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bubble_sort_engine_tb;

    localparam int DW           = 32;
    localparam int MAX_ELEM     = 64;
    localparam int RAND_ITEMS   = 86;
    localparam int HOLD_CYCLES  = 300;
    // run limit, well above the slowest run: ~110 items with long gaps,
    // ~20 sets with their settle phase, results behind long stalls, one long hold
    localparam int unsigned LIMIT = 300000;

    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

    // one element waiting to be sent; drain holds it back until all is out
    typedef struct {
        logic signed [DW-1:0] value;
        logic                 last;
        logic                 drain;
    } t_feed_item;

    // one value the engine must hand back
    typedef struct {
        logic signed [DW-1:0] value;
        logic                 last;
    } t_sorted_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic signed [DW-1:0] i_value     = '0;
    logic                 i_last      = 1'b0;
    logic                 i_ready     = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic signed [DW-1:0] o_value_res;
    logic                 o_last_res;

    t_feed_item           feed_q[$];
    logic signed [DW-1:0] gathered_q[$];
    t_sorted_item         ascending_q[$];

    logic        sort_idle  = 1'b1;
    int unsigned cycle_cnt  = 0;
    int          errors     = 0;
    int          elems_in   = 0;
    int          elems_lost = 0;
    int          sets_done  = 0;
    int          values_out = 0;

    // sender side
    int unsigned feed_gap   = 0;
    // receiver side
    int unsigned sink_gap   = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;
    int unsigned taken      = 0;
    // stretches with no idling at all, drawn separately per side
    logic        feed_calm  = 1'b0;
    logic        sink_calm  = 1'b0;
    int unsigned feed_span  = 0;
    int unsigned sink_span  = 0;

    bubble_sort_engine #(
        .MAX_ELEMENTS (MAX_ELEM),
        .DATA_WIDTH   (DW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap(input logic calm);
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // element value: mostly any pattern, some near zero for duplicates,
    // some at the extremes
    function automatic logic signed [DW-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom;
        if (roll < 85) return $signed($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic queue_elem(input logic signed [DW-1:0] value, input logic last,
                              input logic drain);
        t_feed_item it;
        it.value = value;
        it.last  = last;
        it.drain = drain;
        feed_q.push_back(it);
    endtask

    // software engine: store up to MAX_ELEM values, order the set on the
    // last flag and queue the ascending values it must produce
    task automatic take_element(input logic signed [DW-1:0] value, input logic last);
        t_sorted_item         r;
        logic signed [DW-1:0] held;
        int                   i;
        int                   j;
        elems_in++;
        if (gathered_q.size() < MAX_ELEM) begin
            gathered_q.push_back(value);
        end else begin
            // storage full: value dropped, last flag still closes the set
            elems_lost++;
        end
        if (last) begin
            for (i = 1; i < gathered_q.size(); i++) begin
                held = gathered_q[i];
                j    = i - 1;
                while (j >= 0 && gathered_q[j] > held) begin
                    gathered_q[j + 1] = gathered_q[j];
                    j--;
                end
                gathered_q[j + 1] = held;
            end
            for (i = 0; i < gathered_q.size(); i++) begin
                r.value = gathered_q[i];
                r.last  = (i == gathered_q.size() - 1);
                ascending_q.push_back(r);
            end
            gathered_q.delete();
            sets_done++;
        end
    endtask

    task automatic check_sorted(input logic signed [DW-1:0] value, input logic last);
        t_sorted_item want;
        values_out++;
        if (ascending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got value %0d last %0b",
                     $time, value, last);
        end else begin
            want = ascending_q.pop_front();
            if (value !== want.value) begin
                errors++;
                $display("%0t: value_res mismatch, expected %0d, got %0d",
                         $time, want.value, value);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_res mismatch, expected %0b, got %0b",
                         $time, want.last, last);
            end
        end
    endtask

    // idle-free stretches come and go on each side independently
    always @(posedge i_clk) begin
        if (feed_span == 0) begin
            feed_calm <= ($urandom_range(0, 3) == 0);
            feed_span <= $urandom_range(30, 150);
        end else begin
            feed_span <= feed_span - 1;
        end
        if (sink_span == 0) begin
            sink_calm <= ($urandom_range(0, 3) == 0);
            sink_span <= $urandom_range(30, 150);
        end else begin
            sink_span <= sink_span - 1;
        end
    end

    // driver: offer the head of feed_q, hold it until the transfer, then idle
    // for the gap drawn at offer time; a drain item also waits until the
    // engine has handed back everything owed (only once i_valid is already low,
    // so sort_idle already reflects the previous transfer)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_value  <= '0;
            i_last   <= 1'b0;
            feed_gap <= 0;
        end else if (i_valid && !o_ready) begin
            // offer stays up, payload unchanged
        end else if (feed_gap != 0) begin
            i_valid  <= 1'b0;
            feed_gap <= feed_gap - 1;
        end else if (feed_q.size() != 0
                     && (!feed_q[0].drain || (sort_idle && !i_valid))) begin
            i_valid  <= 1'b1;
            i_value  <= feed_q[0].value;
            i_last   <= feed_q[0].last;
            feed_gap <= pick_gap(feed_calm);
            void'(feed_q.pop_front());
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold after the fifth transfer
    // while the sender keeps offering, so the engine backs up its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            sink_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
            taken     <= 0;
        end else begin
            if (o_valid && i_ready) taken <= taken + 1;
            if (hold_left != 0) begin
                i_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && taken == 5) begin
                i_ready   <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (sink_gap != 0) begin
                i_ready  <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                i_ready  <= 1'b1;
                sink_gap <= pick_gap(sink_calm);
            end
        end
    end

    // monitor: both channels seen at the same edge, so the expected store
    // has a single owner
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sort_idle <= 1'b1;
        end else begin
            if (i_valid && o_ready) take_element(i_value, i_last);
            if (o_valid && i_ready) check_sorted(o_value_res, o_last_res);
            sort_idle <= (ascending_q.size() == 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("%0t: timeout, %0d items unsent, %0d results outstanding",
                     $time, feed_q.size(), ascending_q.size());
            $display("bubble_sort_engine_tb: errors");
            $finish;
        end
    end

    initial begin
        int set_no;
        int set_len;
        int rand_cnt;
        int k;

        // single element at the negative extreme
        queue_elem(VAL_MIN, 1'b1, 1'b0);
        // two extremes, reversed
        queue_elem(VAL_MAX, 1'b0, 1'b0);
        queue_elem(VAL_MIN, 1'b1, 1'b0);
        // mixed signs with duplicates
        queue_elem(32'sd1,  1'b0, 1'b0);
        queue_elem(-32'sd1, 1'b0, 1'b0);
        queue_elem(32'sd0,  1'b0, 1'b0);
        queue_elem(VAL_MAX, 1'b0, 1'b0);
        queue_elem(VAL_MIN, 1'b0, 1'b0);
        queue_elem(32'sd0,  1'b0, 1'b0);
        queue_elem(-32'sd1, 1'b1, 1'b0);
        // already ascending, no swap needed
        queue_elem(-32'sd3,  1'b0, 1'b0);
        queue_elem(32'sd2,   1'b0, 1'b0);
        queue_elem(32'sd7,   1'b0, 1'b0);
        queue_elem(32'sd100, 1'b1, 1'b0);
        // strictly descending, worst case
        queue_elem(32'sd50,      1'b0, 1'b0);
        queue_elem(32'sd20,      1'b0, 1'b0);
        queue_elem(32'sd0,       1'b0, 1'b0);
        queue_elem(-32'sd20,     1'b0, 1'b0);
        queue_elem(VAL_MIN + 1,  1'b1, 1'b0);
        // all equal
        queue_elem(32'sd7, 1'b0, 1'b0);
        queue_elem(32'sd7, 1'b0, 1'b0);
        queue_elem(32'sd7, 1'b1, 1'b0);
        // alternating bit patterns, sign bit set on the second
        queue_elem(32'sh5555_5555, 1'b0, 1'b0);
        queue_elem(32'shAAAA_AAAA, 1'b1, 1'b0);

        // random sets: mostly short, one overrunning the storage; the first
        // and the third wait for the engine to drain completely
        set_no   = 0;
        rand_cnt = 0;
        while (rand_cnt < RAND_ITEMS) begin
            if (set_no == 3)
                set_len = $urandom_range(MAX_ELEM + 1, MAX_ELEM + 8);
            else if ($urandom_range(0, 9) == 0)
                set_len = $urandom_range(9, 20);
            else
                set_len = $urandom_range(1, 8);
            for (k = 0; k < set_len; k++)
                queue_elem(pick_value(), k == set_len - 1,
                           (set_no == 0 || set_no == 2) && k == 0);
            rand_cnt += set_len;
            set_no++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and everything owed handed back
        do @(negedge i_clk);
        while (feed_q.size() != 0 || i_valid || ascending_q.size() != 0);
        // room for a stray extra result
        repeat (MAX_ELEM + 16) @(negedge i_clk);

        $display("sent %0d elements in %0d sets, %0d beyond the storage dropped",
                 elems_in, sets_done, elems_lost);
        $display("checked %0d sorted values, %0d mismatches", values_out, errors);
        if (errors == 0) begin
            $display("bubble_sort_engine_tb: clean");
        end else begin
            $display("bubble_sort_engine_tb: errors");
        end
        $finish;
    end

endmodule
